// File: hdl/fre_pkg.sv
package fre_pkg;

  localparam int unsigned LenWidth = 25;
  localparam int unsigned WordWidth = 32;
  localparam logic [LenWidth-1:0] MaxRun = 25'd16777216;

  typedef enum logic [1:0] {
    CmdLoad = 2'd0,
    CmdPull = 2'd1,
    CmdEnd  = 2'd2
  } fre_cmd_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNonfinite = 3'd1,
    StBadCount  = 3'd2,
    StOverflow  = 3'd3,
    StMismatch  = 3'd4,
    StNotReady  = 3'd5,
    StSticky    = 3'd6
  } fre_status_e;

  typedef struct packed {
    logic [WordWidth-1:0] run_value;
    logic [LenWidth-1:0]  run_remaining;
    logic [LenWidth-1:0]  words_filled;
    logic                 error_latched;
  } fre_state_t;

  typedef struct packed {
    fre_status_e          status;
    logic                 elem_valid;
    logic [WordWidth-1:0] elem_value;
    logic                 last_of_run;
    logic                 stream_done;
  } fre_result_t;

  typedef struct packed {
    logic                ok;
    logic [LenWidth-1:0] count;
  } fre_count_t;

  function automatic logic fre_nonfinite(logic [WordWidth-1:0] bits);
    return bits[30:23] == 8'hFF;
  endfunction

  // Count must be a positive exact integer in 1 .. MaxRun.
  function automatic fre_count_t fre_decode_count(logic [WordWidth-1:0] bits);
    fre_count_t res;
    logic [7:0] expo;
    logic [7:0] e8;
    logic [4:0] e;
    logic [4:0] sh;
    logic [22:0] frac;
    logic [22:0] low_mask;
    logic [23:0] sig;
    logic [LenWidth-1:0] c;
    expo = bits[30:23];
    frac = bits[22:0];
    sig = {1'b1, frac};
    e8 = expo - 8'd127;
    e = e8[4:0];
    res.ok = !bits[31] && (expo >= 8'd127) && (expo <= 8'd151);
    if (e <= 5'd23) begin
      sh = 5'd23 - e;
      low_mask = ~(23'h7FFFFF << sh);
      c = {1'b0, sig} >> sh;
      if ((frac & low_mask) != 23'd0) begin
        res.ok = 1'b0;
      end
    end else begin
      sh = 5'd0;
      low_mask = 23'd0;
      c = {sig, 1'b0};
    end
    if ((c < 25'd1) || (c > MaxRun)) begin
      res.ok = 1'b0;
    end
    res.count = c;
    return res;
  endfunction

endpackage

// File: hdl/fre_step.sv
module fre_step (
  input  logic [1:0]                  cmd_i,
  input  logic [fre_pkg::WordWidth-1:0] value_bits_i,
  input  logic [fre_pkg::WordWidth-1:0] count_bits_i,
  input  logic [fre_pkg::LenWidth-1:0]  total_length_i,
  input  fre_pkg::fre_state_t         state_i,
  output fre_pkg::fre_state_t         state_o,
  output fre_pkg::fre_result_t        result_o
);

  fre_pkg::fre_count_t cnt;
  logic [fre_pkg::LenWidth:0] fill_sum;

  assign cnt = fre_pkg::fre_decode_count(count_bits_i);
  assign fill_sum = {1'b0, state_i.words_filled} + {1'b0, cnt.count};

  always_comb begin
    state_o = state_i;
    result_o.status = fre_pkg::StOk;
    result_o.elem_valid = 1'b0;
    result_o.elem_value = '0;
    result_o.last_of_run = 1'b0;
    result_o.stream_done = 1'b0;

    if (state_i.error_latched) begin
      result_o.status = fre_pkg::StSticky;
    end else begin
      case (cmd_i)
        fre_pkg::CmdLoad: begin
          if (state_i.run_remaining != '0) begin
            result_o.status = fre_pkg::StNotReady;
          end else if (fre_pkg::fre_nonfinite(value_bits_i) ||
                       fre_pkg::fre_nonfinite(count_bits_i)) begin
            result_o.status = fre_pkg::StNonfinite;
            state_o.error_latched = 1'b1;
          end else if (!cnt.ok) begin
            result_o.status = fre_pkg::StBadCount;
            state_o.error_latched = 1'b1;
          end else if (fill_sum > {1'b0, total_length_i}) begin
            result_o.status = fre_pkg::StOverflow;
            state_o.error_latched = 1'b1;
          end else begin
            state_o.run_value = value_bits_i;
            state_o.run_remaining = cnt.count;
          end
        end
        fre_pkg::CmdPull: begin
          if (state_i.run_remaining == '0) begin
            result_o.status = fre_pkg::StNotReady;
          end else begin
            state_o.run_remaining = state_i.run_remaining - 25'd1;
            state_o.words_filled = state_i.words_filled + 25'd1;
            result_o.elem_valid = 1'b1;
            result_o.elem_value = state_i.run_value;
            result_o.last_of_run = (state_i.run_remaining == 25'd1);
          end
        end
        fre_pkg::CmdEnd: begin
          if (state_i.run_remaining != '0) begin
            result_o.status = fre_pkg::StNotReady;
          end else if (state_i.words_filled == total_length_i) begin
            result_o.stream_done = 1'b1;
          end else begin
            result_o.status = fre_pkg::StMismatch;
            state_o.error_latched = 1'b1;
          end
        end
        default: begin
          result_o.status = fre_pkg::StNotReady;
        end
      endcase
    end
  end

endmodule

// File: hdl/float_rle_run_expander.sv
// Run-length expander for float32 (value, count) pairs.
// Input channel (in_valid_i / in_stall_o): one request per item, cmd_i picks
// load pair, pull element or end-of-stream check; value_bits_i and
// count_bits_i matter only for a load.
// Output channel (out_valid_o / out_stall_i): exactly one result per request,
// in order. A pull returns one copy of the run value with last_of_run_o on
// the final copy; an end check raises stream_done_o when the words emitted
// match total_length.
// Config channel (cfg_valid_i / cfg_ready_o): writes total_length, always
// ready, taken at once; write only while the block is idle.
// A request goes from the input register through one step of logic into the
// result register. Throughput: one request per cycle while the receiver does
// not stall; the state update is a single combinational step. When the
// receiver stalls, the result register holds and the input register still
// takes one more request; after that in_stall_o rises.
// Reset clears the run, the fill count, the sticky error, total_length and
// both stages. Errors stay latched until reset.
module float_rle_run_expander (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [fre_pkg::WordWidth-1:0] value_bits_i,
  input  logic [fre_pkg::WordWidth-1:0] count_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic                          elem_valid_o,
  output logic [fre_pkg::WordWidth-1:0] elem_value_o,
  output logic                          last_of_run_o,
  output logic                          stream_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fre_pkg::LenWidth-1:0]  cfg_data_i
);

  logic                          in_valid_q;
  logic [1:0]                    cmd_q;
  logic [fre_pkg::WordWidth-1:0] value_q;
  logic [fre_pkg::WordWidth-1:0] count_q;
  logic                          out_valid_q;
  fre_pkg::fre_result_t          result_d, result_q;
  fre_pkg::fre_state_t           state_d, state_q;
  logic [fre_pkg::LenWidth-1:0]  total_length_q;
  logic                          in_accept;
  logic                          advance;

  assign advance = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  fre_step u_step (
    .cmd_i          (cmd_q),
    .value_bits_i   (value_q),
    .count_bits_i   (count_q),
    .total_length_i (total_length_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_i;
      value_q <= value_bits_i;
      count_q <= count_bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      state_q     <= state_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_length_q <= '0;
    end else if (cfg_valid_i) begin
      total_length_q <= cfg_data_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = result_q.status;
  assign elem_valid_o  = result_q.elem_valid;
  assign elem_value_o  = result_q.elem_value;
  assign last_of_run_o = result_q.last_of_run;
  assign stream_done_o = result_q.stream_done;

endmodule

// File: hdl/fre_checker.sv
module fre_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [2:0]                    status_o,
  input logic                          elem_valid_o,
  input logic [fre_pkg::WordWidth-1:0] elem_value_o,
  input logic                          last_of_run_o,
  input logic                          stream_done_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(elem_value_o) && $stable(elem_valid_o))
    else $error("stalled result changed");

  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && elem_valid_o |-> status_o == fre_pkg::StOk && !stream_done_o)
    else $error("element emitted with non-ok status");

  a_last_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> elem_valid_o)
    else $error("last_of_run without element");

  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> status_o == fre_pkg::StOk && elem_value_o == '0)
    else $error("stream_done with bad status or payload");

endmodule

bind float_rle_run_expander fre_checker u_fre_checker (.*);

// File: bench/float_rle_run_expander_tb.sv
`timescale 1ns / 1ps

module float_rle_run_expander_tb;

  localparam logic [1:0] CmdSpare = 2'd3;  // unused code, answers not ready
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 60;

  typedef enum logic {RowReq, RowLen} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [1:0]           cmd;
    logic [31:0]          v;      // value bits, or the length for RowLen
    logic [31:0]          c;
    bit                   typed;
    fre_pkg::fre_result_t want;
  } dir_row_t;

  typedef enum int {
    CloseBadValue, CloseBadCountWord, CloseBadCount, CloseOverflow, CloseMismatch,
    CloseLongRun
  } closing_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  cmd_r = 2'd0;
  logic [31:0] value_r = 32'd0;
  logic [31:0] count_r = 32'd0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [24:0] cfg_data = 25'd0;

  logic        in_stall_o, out_valid_o, cfg_ready_o;
  logic [2:0]  status_o;
  logic        elem_valid_o, last_of_run_o, stream_done_o;
  logic [31:0] elem_value_o;

  // predictor state
  logic [31:0] run_val = 32'd0;
  logic [24:0] run_left = 25'd0;
  logic [24:0] filled_cnt = 25'd0;
  logic [24:0] total_len = 25'd0;
  bit          err_sticky = 1'b0;

  fre_pkg::fre_result_t expanded_q [$];
  dir_row_t             dir_rows [$];

  logic [31:0] bad_counts [8] = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000,
                                  32'h3F00_0000, 32'h3FC0_0000, 32'h4B80_0001,
                                  32'h4C00_0000, 32'h0000_0001};

  int  n_fail = 0;
  int  n_items = 0;
  int  n_cfg = 0;
  int  n_words = 0;
  int  n_done = 0;
  int  n_sticky = 0;
  int  idle_cycles = 0;
  bit  send_fast = 1'b0;
  bit  rx_fast = 1'b0;
  bit  hold_req = 1'b0;

  float_rle_run_expander u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_r),
    .value_bits_i  (value_r),
    .count_bits_i  (count_r),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .elem_valid_o  (elem_valid_o),
    .elem_value_o  (elem_value_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic fre_pkg::fre_result_t res(fre_pkg::fre_status_e st, logic ev,
                                               logic [31:0] val, logic lr, logic sd);
    fre_pkg::fre_result_t r;
    r.status = st;
    r.elem_valid = ev;
    r.elem_value = val;
    r.last_of_run = lr;
    r.stream_done = sd;
    return r;
  endfunction

  // {ok, count}: positive exact integer 1 .. 2^24
  function automatic logic [25:0] count_from_bits(logic [31:0] b);
    logic [7:0] ex;
    logic [31:0] sig;
    logic [31:0] cnt;
    int unsigned sh;
    ex = b[30:23];
    sig = {8'd0, 1'b1, b[22:0]};
    if (b[31] || ex < 8'd127 || ex > 8'd151) return 26'd0;
    if (ex < 8'd150) begin
      sh = 150 - ex;
      if ((sig & ((32'd1 << sh) - 32'd1)) != 32'd0) return 26'd0;
      cnt = sig >> sh;
    end else begin
      cnt = sig << (ex - 8'd150);
    end
    if (cnt < 32'd1 || cnt > 32'd16777216) return 26'd0;
    return {1'b1, cnt[24:0]};
  endfunction

  function automatic logic [31:0] count_to_bits(logic [24:0] n);
    int p;
    logic [31:0] m;
    logic [7:0] ex;
    p = 0;
    for (int i = 0; i < 25; i++) if (n[i]) p = i;
    m = (p <= 23) ? ({7'd0, n} << (23 - p)) : ({7'd0, n} >> (p - 23));
    ex = 8'(127 + p);
    return {1'b0, ex, m[22:0]};
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h0000_0000;
      1: v = 32'h8000_0000;
      2: v = 32'h7F7F_FFFF;
      3: v = 32'hFF7F_FFFF;
      default: v = $urandom();
    endcase
    if (v[30:23] == 8'hFF) v[23] = 1'b0;  // keep it finite
    return v;
  endfunction

  function automatic fre_pkg::fre_result_t expander_step(logic [1:0] cmd, logic [31:0] v,
                                                         logic [31:0] c);
    fre_pkg::fre_result_t r;
    logic [25:0] dec;
    r = res(fre_pkg::StOk, 1'b0, 32'd0, 1'b0, 1'b0);
    if (err_sticky) begin
      r.status = fre_pkg::StSticky;
    end else begin
      case (cmd)
        fre_pkg::CmdLoad: begin
          dec = count_from_bits(c);
          if (run_left != 25'd0) begin
            r.status = fre_pkg::StNotReady;
          end else if (v[30:23] == 8'hFF || c[30:23] == 8'hFF) begin
            r.status = fre_pkg::StNonfinite;
          end else if (!dec[25]) begin
            r.status = fre_pkg::StBadCount;
          end else if ({1'b0, filled_cnt} + {1'b0, dec[24:0]} > {1'b0, total_len}) begin
            r.status = fre_pkg::StOverflow;
          end else begin
            run_val = v;
            run_left = dec[24:0];
          end
          if (r.status == fre_pkg::StNonfinite || r.status == fre_pkg::StBadCount ||
              r.status == fre_pkg::StOverflow) begin
            err_sticky = 1'b1;
          end
        end
        fre_pkg::CmdPull: begin
          if (run_left == 25'd0) begin
            r.status = fre_pkg::StNotReady;
          end else begin
            run_left = run_left - 25'd1;
            filled_cnt = filled_cnt + 25'd1;
            r.elem_valid = 1'b1;
            r.elem_value = run_val;
            r.last_of_run = (run_left == 25'd0);
          end
        end
        fre_pkg::CmdEnd: begin
          if (run_left != 25'd0) begin
            r.status = fre_pkg::StNotReady;
          end else if (filled_cnt == total_len) begin
            r.stream_done = 1'b1;
          end else begin
            r.status = fre_pkg::StMismatch;
            err_sticky = 1'b1;
          end
        end
        default: r.status = fre_pkg::StNotReady;
      endcase
    end
    return r;
  endfunction

  task automatic flag(input string what);
    n_fail++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic push_req(input logic [1:0] cmd, input logic [31:0] v, input logic [31:0] c,
                          input bit typed, input fre_pkg::fre_result_t want);
    int gap;
    fre_pkg::fre_result_t pred;
    gap = send_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_r <= cmd;
    value_r <= v;
    count_r <= c;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    pred = expander_step(cmd, v, c);
    expanded_q.push_back(typed ? want : pred);
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expanded_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_total(input logic [24:0] len);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    total_len = len;
    n_cfg++;
  endtask

  // noise that never latches an error
  task automatic maybe_noise(input bit pending);
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0: push_req(CmdSpare, $urandom(), $urandom(), 1'b0, '0);
        1: push_req(pending ? fre_pkg::CmdLoad : fre_pkg::CmdPull, $urandom(), $urandom(),
                    1'b0, '0);
        default: push_req(pending ? fre_pkg::CmdEnd : CmdSpare, $urandom(), $urandom(),
                          1'b0, '0);
      endcase
    end
  endtask

  function automatic void add_row(row_kind_e kind, logic [1:0] cmd, logic [31:0] v,
                                  logic [31:0] c, bit typed, fre_pkg::fre_result_t want);
    dir_row_t row;
    row.kind = kind;
    row.cmd = cmd;
    row.v = v;
    row.c = c;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // receiver: random stall per result, one long hold on request
  initial begin : receiver
    int gap;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        gap = HoldCycles;
        hold_req = 1'b0;
      end else begin
        gap = rx_fast ? 0 : $urandom_range(0, 6);
      end
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk) begin : result_check
    fre_pkg::fre_result_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (expanded_q.size() == 0) begin
        flag($sformatf("result with status %0d and nothing outstanding", status_o));
      end else begin
        want = expanded_q.pop_front();
        if (status_o !== want.status)
          flag($sformatf("status got %0d want %0d", status_o, want.status));
        if (elem_valid_o !== want.elem_valid)
          flag($sformatf("elem_valid got %0b want %0b", elem_valid_o, want.elem_valid));
        if (elem_value_o !== want.elem_value)
          flag($sformatf("elem_value got %h want %h", elem_value_o, want.elem_value));
        if (last_of_run_o !== want.last_of_run)
          flag($sformatf("last_of_run got %0b want %0b", last_of_run_o, want.last_of_run));
        if (stream_done_o !== want.stream_done)
          flag($sformatf("stream_done got %0b want %0b", stream_done_o, want.stream_done));
        if (want.elem_valid) n_words++;
        if (want.stream_done) n_done++;
        if (want.status == fre_pkg::StSticky) n_sticky++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("timeout: no request moved for %0d cycles", StallLimit);
      $display("float_rle_run_expander regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    int i;
    int k;
    int nruns;
    int unsigned lens [4];
    logic [24:0] sum;
    bit exact;
    bit hold_done;
    logic [31:0] r;
    closing_e closing;

    hold_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle answers, both length extremes, short runs
    add_row(RowReq, fre_pkg::CmdEnd, 32'h0, 32'h0, 1'b1,
            res(fre_pkg::StOk, 1'b0, 32'h0, 1'b0, 1'b1));
    add_row(RowReq, fre_pkg::CmdPull, '1, '1, 1'b1,
            res(fre_pkg::StNotReady, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, CmdSpare, '1, '1, 1'b1,
            res(fre_pkg::StNotReady, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowLen, fre_pkg::CmdLoad, 32'd0, 32'h0, 1'b0, '0);
    add_row(RowReq, fre_pkg::CmdEnd, 32'h0, 32'h0, 1'b1,
            res(fre_pkg::StOk, 1'b0, 32'h0, 1'b0, 1'b1));
    add_row(RowLen, fre_pkg::CmdLoad, {7'd0, fre_pkg::MaxRun}, 32'h0, 1'b0, '0);
    add_row(RowReq, fre_pkg::CmdLoad, 32'h0, 32'h3F80_0000, 1'b1,
            res(fre_pkg::StOk, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, fre_pkg::CmdLoad, '1, '1, 1'b1,
            res(fre_pkg::StNotReady, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, fre_pkg::CmdEnd, '1, '1, 1'b1,
            res(fre_pkg::StNotReady, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, CmdSpare, 32'h0, 32'h0, 1'b1,
            res(fre_pkg::StNotReady, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, fre_pkg::CmdPull, 32'h0, 32'h0, 1'b1,
            res(fre_pkg::StOk, 1'b1, 32'h0, 1'b1, 1'b0));
    add_row(RowReq, fre_pkg::CmdPull, 32'h0, 32'h0, 1'b1,
            res(fre_pkg::StNotReady, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, fre_pkg::CmdLoad, 32'hFF7F_FFFF, 32'h4040_0000, 1'b0, '0);
    for (i = 0; i < 3; i++) add_row(RowReq, fre_pkg::CmdPull, 32'h0, 32'h0, 1'b0, '0);
    add_row(RowReq, fre_pkg::CmdLoad, 32'h8000_0001, 32'h4000_0000, 1'b0, '0);
    for (i = 0; i < 2; i++) add_row(RowReq, fre_pkg::CmdPull, '1, '1, 1'b0, '0);
    add_row(RowReq, fre_pkg::CmdLoad, 32'h7F7F_FFFF, 32'h3F80_0000, 1'b1,
            res(fre_pkg::StOk, 1'b0, 32'h0, 1'b0, 1'b0));
    add_row(RowReq, fre_pkg::CmdPull, 32'h0, 32'h0, 1'b1,
            res(fre_pkg::StOk, 1'b1, 32'h7F7F_FFFF, 1'b1, 1'b0));
    add_row(RowLen, fre_pkg::CmdLoad, 32'd7, 32'h0, 1'b0, '0);
    add_row(RowReq, fre_pkg::CmdEnd, 32'h0, 32'h0, 1'b0, '0);

    foreach (dir_rows[j]) begin
      if (dir_rows[j].kind == RowLen) write_total(dir_rows[j].v[24:0]);
      else push_req(dir_rows[j].cmd, dir_rows[j].v, dir_rows[j].c, dir_rows[j].typed,
                    dir_rows[j].want);
    end

    // random streams, kept free of latched errors
    while (n_items < 600) begin
      exact = ($urandom_range(0, 4) != 0);
      nruns = $urandom_range(1, 4);
      send_fast = ($urandom_range(0, 3) == 0);
      if (!hold_done && n_items > 200) begin
        nruns = 1;
        exact = 1'b1;
        send_fast = 1'b1;
      end
      sum = 25'd0;
      for (i = 0; i < nruns; i++) begin
        lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if (!hold_done && n_items > 200) lens[i] = 48;
        sum = sum + 25'(lens[i]);
      end
      write_total(exact ? filled_cnt + sum : fre_pkg::MaxRun);
      if (!hold_done && n_items > 200) begin
        hold_done = 1'b1;
        hold_req = 1'b1;  // receiver holds off while pulls keep coming
      end
      for (i = 0; i < nruns; i++) begin
        maybe_noise(1'b0);
        push_req(fre_pkg::CmdLoad, rand_value(), count_to_bits(25'(lens[i])), 1'b0, '0);
        for (k = 0; k < lens[i]; k++) begin
          maybe_noise(1'b1);
          push_req(fre_pkg::CmdPull, $urandom(), $urandom(), 1'b0, '0);
        end
      end
      maybe_noise(1'b0);
      if (exact) push_req(fre_pkg::CmdEnd, $urandom(), $urandom(), 1'b0, '0);
    end

    // closing case, then whatever follows it
    send_fast = 1'b0;
    wait_idle();
    closing = closing_e'($urandom_range(0, 5));
    r = $urandom();
    case (closing)
      CloseBadValue:
        push_req(fre_pkg::CmdLoad, {r[31], 8'hFF, r[22:0]}, 32'h8000_0000, 1'b1,
                 res(fre_pkg::StNonfinite, 1'b0, 32'h0, 1'b0, 1'b0));
      CloseBadCountWord:
        push_req(fre_pkg::CmdLoad, rand_value(), {r[31], 8'hFF, r[22:0]}, 1'b1,
                 res(fre_pkg::StNonfinite, 1'b0, 32'h0, 1'b0, 1'b0));
      CloseBadCount:
        push_req(fre_pkg::CmdLoad, rand_value(), bad_counts[$urandom_range(0, 7)], 1'b1,
                 res(fre_pkg::StBadCount, 1'b0, 32'h0, 1'b0, 1'b0));
      CloseOverflow: begin
        write_total(filled_cnt);
        push_req(fre_pkg::CmdLoad, rand_value(), 32'h4B80_0000, 1'b1,
                 res(fre_pkg::StOverflow, 1'b0, 32'h0, 1'b0, 1'b0));
      end
      CloseMismatch: begin
        write_total(filled_cnt + 25'd1);
        push_req(fre_pkg::CmdEnd, $urandom(), $urandom(), 1'b1,
                 res(fre_pkg::StMismatch, 1'b0, 32'h0, 1'b0, 1'b0));
      end
      default: begin
        // longest run that still fits
        write_total(fre_pkg::MaxRun);
        push_req(fre_pkg::CmdLoad, rand_value(), count_to_bits(fre_pkg::MaxRun - filled_cnt),
                 1'b0, '0);
      end
    endcase
    for (i = 0; i < 30; i++) begin
      push_req(2'($urandom_range(0, 3)), $urandom(), $urandom(), 1'b0, '0);
    end

    wait_idle();
    $display("covered %0d requests, %0d expanded words, %0d completed streams",
             n_items, n_words, n_done);
    $display("%0d length writes, closing case %0d, %0d sticky answers after the error",
             n_cfg, closing, n_sticky);
    if (n_fail == 0) begin
      $display("float_rle_run_expander regression: pass");
    end else begin
      $display("float_rle_run_expander regression: fail");
    end
    $finish;
  end

endmodule
